/* rtl/fdbp_pkg.sv */
// ----------------------------------------------------------------------------
// fdbp_pkg
// Shared types and constants of the frequency-domain beamformer power unit.
// ----------------------------------------------------------------------------
package fdbp_pkg;

    localparam int SMP_W       = 16;
    localparam int PROD_W      = 18;
    localparam int ACC_W       = 32;
    localparam int POW_W       = 63;
    localparam int IDX_W       = 6;
    localparam int QUEUE_DEPTH = 4;

    // queue entry: pa/pb hold the phased sample for a sample request and the
    // sign-extended steering entry for a load request
    typedef struct packed {
        logic                     is_load;
        logic                     is_last;
        logic [IDX_W-1:0]         ch;
        logic [IDX_W-1:0]         ang;
        logic signed [PROD_W-1:0] pa;
        logic signed [PROD_W-1:0] pb;
    } t_qent;

endpackage

/* rtl/fdbp_ram.sv */
// ----------------------------------------------------------------------------
// fdbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fdbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/fdbp_fifo.sv */
// ----------------------------------------------------------------------------
// fdbp_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module fdbp_fifo
    import fdbp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_qent o_ent
);

    localparam int QAW = $clog2(QUEUE_DEPTH);

    t_qent          r_buf [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_ready = (r_cnt != (QAW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_buf[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/fdbp_front.sv */
// ----------------------------------------------------------------------------
// fdbp_front
// Accepts requests, drops out-of-range ones, applies the channel phase
// factor to samples and pushes the result into the queue.
// ----------------------------------------------------------------------------
module fdbp_front
    import fdbp_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int NUM_ANGLES   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_req_type,
    input  logic [IDX_W-1:0]        i_channel,
    input  logic [IDX_W-1:0]        i_angle,
    input  logic signed [SMP_W-1:0] i_sample_re,
    input  logic signed [SMP_W-1:0] i_sample_im,
    input  logic signed [SMP_W-1:0] i_phase_cos,
    input  logic signed [SMP_W-1:0] i_phase_sin,
    input  logic signed [SMP_W-1:0] i_steer_re,
    input  logic signed [SMP_W-1:0] i_steer_im,
    output logic                    o_q_push,
    output t_qent                   o_q_ent,
    input  logic                    i_q_ready
);

    logic                    r_v;
    logic                    r_is_load;
    logic                    r_last;
    logic [IDX_W-1:0]        r_ch;
    logic [IDX_W-1:0]        r_ang;
    logic signed [SMP_W-1:0] r_sre;
    logic signed [SMP_W-1:0] r_sim;
    logic signed [31:0]      r_m0;
    logic signed [31:0]      r_m1;
    logic signed [31:0]      r_m2;
    logic signed [31:0]      r_m3;
    logic                    in_range;
    logic                    accept;
    logic [32:0]             d_re;
    logic [32:0]             d_im;

    assign in_range = ({1'b0, i_channel} < (IDX_W+1)'(NUM_CHANNELS)) &&
                      (i_req_type || ({1'b0, i_angle} < (IDX_W+1)'(NUM_ANGLES)));
    assign accept   = i_in_valid && o_in_ready;
    assign o_in_ready = !r_v || i_q_ready;
    assign o_q_push   = r_v;

    assign d_re = {r_m0[31], r_m0} - {r_m1[31], r_m1};
    assign d_im = {r_m2[31], r_m2} + {r_m3[31], r_m3};

    always_comb begin
        o_q_ent.is_load = r_is_load;
        o_q_ent.is_last = r_last;
        o_q_ent.ch      = r_ch;
        o_q_ent.ang     = r_ang;
        if (r_is_load) begin
            o_q_ent.pa = {{(PROD_W-SMP_W){r_sre[SMP_W-1]}}, r_sre};
            o_q_ent.pb = {{(PROD_W-SMP_W){r_sim[SMP_W-1]}}, r_sim};
        end else begin
            o_q_ent.pa = d_re[32:15];
            o_q_ent.pb = d_im[32:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= in_range;
        end else if (i_q_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_load <= !i_req_type;
            r_last    <= ({1'b0, i_channel} == (IDX_W+1)'(NUM_CHANNELS - 1));
            r_ch      <= i_channel;
            r_ang     <= i_angle;
            r_sre     <= i_steer_re;
            r_sim     <= i_steer_im;
            r_m0      <= i_sample_re * i_phase_cos;
            r_m1      <= i_sample_im * i_phase_sin;
            r_m2      <= i_sample_re * i_phase_sin;
            r_m3      <= i_sample_im * i_phase_cos;
        end
    end

endmodule

/* rtl/fdbp_back.sv */
// ----------------------------------------------------------------------------
// fdbp_back
// Executes queued requests: steering table writes, per-angle complex MAC
// into saturating accumulators, and per-angle power readout.
// ----------------------------------------------------------------------------
module fdbp_back
    import fdbp_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int NUM_ANGLES   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_qent            i_q_ent,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [IDX_W-1:0] o_out_angle,
    output logic [POW_W-1:0] o_power,
    output logic             o_last
);

    localparam int TBL_DEPTH = NUM_CHANNELS * NUM_ANGLES;
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int ANG_AW    = (NUM_ANGLES > 1) ? $clog2(NUM_ANGLES) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_EWAIT = 3'd4;

    logic [2:0]               r_state;
    logic [ANG_AW-1:0]        r_cnt;
    logic [TBL_AW-1:0]        r_base;
    logic                     r_last_ch;
    logic signed [PROD_W-1:0] r_p_re;
    logic signed [PROD_W-1:0] r_p_im;
    logic [NUM_ANGLES-1:0]    r_accv;

    logic                     r_m1_v;
    logic [ANG_AW-1:0]        r_m1_ang;
    logic                     r_m1_ok;
    logic                     r_m2_v;
    logic [ANG_AW-1:0]        r_m2_ang;
    logic signed [33:0]       r_pr0;
    logic signed [33:0]       r_pr1;
    logic signed [33:0]       r_pr2;
    logic signed [33:0]       r_pr3;
    logic [ACC_W-1:0]         r_a_re;
    logic [ACC_W-1:0]         r_a_im;

    logic                     r_e1_v;
    logic [ANG_AW-1:0]        r_e1_ang;
    logic                     r_e1_ok;
    logic                     r_e2_v;
    logic [ANG_AW-1:0]        r_e2_ang;
    logic [POW_W-1:0]         r_sq_re;
    logic [POW_W-1:0]         r_sq_im;
    logic                     r_out_v;

    logic                     st_we;
    logic [TBL_AW-1:0]        st_waddr;
    logic [TBL_AW-1:0]        st_raddr;
    logic [2*SMP_W-1:0]       st_rdata;
    logic [2*ACC_W-1:0]       acc_wdata;
    logic [2*ACC_W-1:0]       acc_rdata;
    logic signed [SMP_W-1:0]  w_re;
    logic signed [SMP_W-1:0]  w_im;
    logic [34:0]              s_re;
    logic [34:0]              s_im;
    logic [32:0]              u_re;
    logic [32:0]              u_im;
    logic [ACC_W-1:0]         n_acc_re;
    logic [ACC_W-1:0]         n_acc_im;
    logic signed [ACC_W-1:0]  e_re;
    logic signed [ACC_W-1:0]  e_im;
    logic signed [63:0]       sq_re;
    logic signed [63:0]       sq_im;
    logic [63:0]              pw_sum;
    logic                     out_load;
    logic                     cnt_end;

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign st_we    = o_q_pop && i_q_ent.is_load;
    assign st_waddr = TBL_AW'(32'(i_q_ent.ch) * 32'(NUM_ANGLES)) + TBL_AW'(i_q_ent.ang);
    assign st_raddr = r_base + TBL_AW'(r_cnt);
    assign cnt_end  = (r_cnt == ANG_AW'(NUM_ANGLES - 1));

    fdbp_ram #(
        .WIDTH (2*SMP_W),
        .DEPTH (TBL_DEPTH)
    ) u_steer_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata ({i_q_ent.pb[SMP_W-1:0], i_q_ent.pa[SMP_W-1:0]}),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    fdbp_ram #(
        .WIDTH (2*ACC_W),
        .DEPTH (NUM_ANGLES)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_m2_v),
        .i_waddr (r_m2_ang),
        .i_wdata (acc_wdata),
        .i_raddr (r_cnt),
        .o_rdata (acc_rdata)
    );

    // MAC: products of phased sample and conjugated steering entry
    assign w_re = st_rdata[SMP_W-1:0];
    assign w_im = st_rdata[2*SMP_W-1:SMP_W];

    assign s_re = {r_pr0[33], r_pr0} + {r_pr1[33], r_pr1};
    assign s_im = {r_pr2[33], r_pr2} - {r_pr3[33], r_pr3};
    assign u_re = {r_a_re[ACC_W-1], r_a_re} + {{13{s_re[34]}}, s_re[34:15]};
    assign u_im = {r_a_im[ACC_W-1], r_a_im} + {{13{s_im[34]}}, s_im[34:15]};

    always_comb begin
        if (u_re[32] != u_re[31]) begin
            n_acc_re = u_re[32] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            n_acc_re = u_re[ACC_W-1:0];
        end
        if (u_im[32] != u_im[31]) begin
            n_acc_im = u_im[32] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            n_acc_im = u_im[ACC_W-1:0];
        end
    end

    assign acc_wdata = {n_acc_im, n_acc_re};

    // power readout
    assign e_re   = r_e1_ok ? acc_rdata[ACC_W-1:0] : '0;
    assign e_im   = r_e1_ok ? acc_rdata[2*ACC_W-1:ACC_W] : '0;
    assign sq_re  = e_re * e_re;
    assign sq_im  = e_im * e_im;
    assign pw_sum = {1'b0, r_sq_re} + {1'b0, r_sq_im};
    assign out_load = r_e2_v && (!r_out_v || i_out_ready);

    assign o_out_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_accv  <= '0;
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_e1_v  <= 1'b0;
            r_e2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_m1_v <= (r_state == S_MAC);
            r_m2_v <= r_m1_v;
            r_e1_v <= (r_state == S_EMIT);
            if (r_m2_v) begin
                r_accv[r_m2_ang] <= 1'b1;
            end
            if (r_e1_v) begin
                r_e2_v <= 1'b1;
            end else if (out_load) begin
                r_e2_v <= 1'b0;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && !i_q_ent.is_load) begin
                        r_cnt   <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (cnt_end) begin
                        r_cnt   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_m1_v && !r_m2_v) begin
                        r_state <= r_last_ch ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT: begin
                    r_state <= S_EWAIT;
                end
                S_EWAIT: begin
                    if (!r_e1_v && !r_e2_v) begin
                        if (cnt_end) begin
                            r_cnt   <= '0;
                            r_accv  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= S_EMIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && !i_q_ent.is_load) begin
            r_base    <= TBL_AW'(32'(i_q_ent.ch) * 32'(NUM_ANGLES));
            r_last_ch <= i_q_ent.is_last;
            r_p_re    <= i_q_ent.pa;
            r_p_im    <= i_q_ent.pb;
        end
        r_m1_ang <= r_cnt;
        r_m1_ok  <= r_accv[r_cnt];
        r_m2_ang <= r_m1_ang;
        r_pr0    <= r_p_re * w_re;
        r_pr1    <= r_p_im * w_im;
        r_pr2    <= r_p_im * w_re;
        r_pr3    <= r_p_re * w_im;
        r_a_re   <= r_m1_ok ? acc_rdata[ACC_W-1:0] : '0;
        r_a_im   <= r_m1_ok ? acc_rdata[2*ACC_W-1:ACC_W] : '0;
        r_e1_ang <= r_cnt;
        r_e1_ok  <= r_accv[r_cnt];
        if (r_e1_v) begin
            r_e2_ang <= r_e1_ang;
            r_sq_re  <= sq_re[POW_W-1:0];
            r_sq_im  <= sq_im[POW_W-1:0];
        end
        if (out_load) begin
            o_out_angle <= IDX_W'(r_e2_ang);
            o_power     <= pw_sum[63] ? {POW_W{1'b1}} : pw_sum[POW_W-1:0];
            o_last      <= (r_e2_ang == ANG_AW'(NUM_ANGLES - 1));
        end
    end

endmodule

/* rtl/freq_domain_beamformer_power_unit.sv */
// ----------------------------------------------------------------------------
// freq_domain_beamformer_power_unit
// A request passes the front's register and then the queue. The back writes a load
// into the steering table as it pops it and runs a sample as one MAC per angle
// through the steering RAM port; a last-channel sample adds a power readout per angle.
// The back pops no new request until it is through with the current sample.
// Reset clears control state and accumulator valid bits; steering table is not cleared.
// ----------------------------------------------------------------------------
module freq_domain_beamformer_power_unit
    import fdbp_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int NUM_ANGLES   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_req_type,
    input  logic [IDX_W-1:0]        i_channel,
    input  logic [IDX_W-1:0]        i_angle,
    input  logic signed [SMP_W-1:0] i_sample_re,
    input  logic signed [SMP_W-1:0] i_sample_im,
    input  logic signed [SMP_W-1:0] i_phase_cos,
    input  logic signed [SMP_W-1:0] i_phase_sin,
    input  logic signed [SMP_W-1:0] i_steer_re,
    input  logic signed [SMP_W-1:0] i_steer_im,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [IDX_W-1:0]        o_out_angle,
    output logic [POW_W-1:0]        o_power,
    output logic                    o_last
);

    logic  f_push;
    t_qent f_ent;
    logic  q_ready;
    logic  q_valid;
    t_qent q_ent;
    logic  q_pop;

    fdbp_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_ANGLES   (NUM_ANGLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_channel   (i_channel),
        .i_angle     (i_angle),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .i_phase_cos (i_phase_cos),
        .i_phase_sin (i_phase_sin),
        .i_steer_re  (i_steer_re),
        .i_steer_im  (i_steer_im),
        .o_q_push    (f_push),
        .o_q_ent     (f_ent),
        .i_q_ready   (q_ready)
    );

    fdbp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_ent   (f_ent),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_ent   (q_ent)
    );

    fdbp_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_ANGLES   (NUM_ANGLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_ent     (q_ent),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_angle (o_out_angle),
        .o_power     (o_power),
        .o_last      (o_last)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the beamformer power unit. Steering loads and
// channel samples go in through a valid/ready driver; a scoreboard mirrors the
// steering table and the saturating beam accumulators and checks every angle
// power in order. Covers out-of-range requests, missing and repeated channels,
// backpressure and the largest per-angle contributions.
// ----------------------------------------------------------------------------
module tb_top;
    import fdbp_pkg::*;

    localparam int N_CH        = 8;
    localparam int N_ANG       = 16;
    localparam bit REQ_LOAD    = 1'b0;
    localparam bit REQ_SAMPLE  = 1'b1;
    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 4000;
    localparam int BIG_SAMPLES = 16;
    localparam longint ACC_HI  = 64'sd2147483647;
    localparam longint ACC_LO  = -64'sd2147483648;
    localparam logic [63:0] POWER_HI = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        channel;
        logic [IDX_W-1:0]        angle;
        logic signed [SMP_W-1:0] sample_re;
        logic signed [SMP_W-1:0] sample_im;
        logic signed [SMP_W-1:0] phase_cos;
        logic signed [SMP_W-1:0] phase_sin;
        logic signed [SMP_W-1:0] steer_re;
        logic signed [SMP_W-1:0] steer_im;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] angle;
        logic [POW_W-1:0] power;
        logic             is_last;
    } t_angle_power;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    t_req drv       = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [IDX_W-1:0] o_out_angle;
    logic [POW_W-1:0] o_power;
    logic             o_last;

    t_req         req_backlog[$];
    t_angle_power pending_powers[$];

    logic [31:0] steer_tbl[N_CH*N_ANG];
    int          beam_re[N_ANG];
    int          beam_im[N_ANG];
    bit          gen_loaded[N_CH*N_ANG];

    int tx_idle_pct = 19;
    int rx_idle_pct = 60;
    bit hold_arm    = 1'b0;
    bit hold_taken  = 1'b0;
    int hold_left   = 0;
    int fail_cnt    = 0;
    int useful_items = 0;
    int stall_cycles = 0;

    freq_domain_beamformer_power_unit #(
        .NUM_CHANNELS(N_CH),
        .NUM_ANGLES  (N_ANG)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (drv.req_type),
        .i_channel  (drv.channel),
        .i_angle    (drv.angle),
        .i_sample_re(drv.sample_re),
        .i_sample_im(drv.sample_im),
        .i_phase_cos(drv.phase_cos),
        .i_phase_sin(drv.phase_sin),
        .i_steer_re (drv.steer_re),
        .i_steer_im (drv.steer_im),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_angle(o_out_angle),
        .o_power    (o_power),
        .o_last     (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- scoreboard model ----------------

    function automatic int sat_acc(int acc, longint delta);
        longint s;
        s = longint'(acc) + delta;
        if (s > ACC_HI) s = ACC_HI;
        if (s < ACC_LO) s = ACC_LO;
        return int'(s);
    endfunction

    function automatic void beam_step(t_req r);
        longint p_re, p_im, w_re, w_im, m_re, m_im;
        logic [63:0] pw;
        logic [31:0] e;
        t_angle_power res;
        int base;
        base = int'(r.channel) * N_ANG;
        if (r.req_type == REQ_LOAD) begin
            if (r.channel < N_CH && r.angle < N_ANG)
                steer_tbl[base + int'(r.angle)] = {r.steer_im, r.steer_re};
            return;
        end
        if (r.channel >= N_CH) return;
        p_re = (longint'(r.sample_re) * r.phase_cos - longint'(r.sample_im) * r.phase_sin) >>> 15;
        p_im = (longint'(r.sample_re) * r.phase_sin + longint'(r.sample_im) * r.phase_cos) >>> 15;
        for (int a = 0; a < N_ANG; a++) begin
            e    = steer_tbl[base + a];
            w_re = longint'($signed(e[15:0]));
            w_im = longint'($signed(e[31:16]));
            beam_re[a] = sat_acc(beam_re[a], (p_re * w_re + p_im * w_im) >>> 15);
            beam_im[a] = sat_acc(beam_im[a], (p_im * w_re - p_re * w_im) >>> 15);
        end
        if (r.channel != N_CH - 1) return;
        for (int a = 0; a < N_ANG; a++) begin
            m_re = (beam_re[a] < 0) ? -longint'(beam_re[a]) : longint'(beam_re[a]);
            m_im = (beam_im[a] < 0) ? -longint'(beam_im[a]) : longint'(beam_im[a]);
            pw   = 64'(m_re) * 64'(m_re) + 64'(m_im) * 64'(m_im);
            if (pw > POWER_HI) pw = POWER_HI;
            res.angle   = IDX_W'(a);
            res.power   = pw[POW_W-1:0];
            res.is_last = (a == N_ANG - 1);
            pending_powers.push_back(res);
            beam_re[a] = 0;
            beam_im[a] = 0;
        end
    endfunction

    function automatic void check_power();
        t_angle_power want;
        if (pending_powers.size() == 0) begin
            $error("unexpected result: out_angle=%0d power=%0d last=%0b",
                   o_out_angle, o_power, o_last);
            fail_cnt++;
            return;
        end
        want = pending_powers.pop_front();
        if (o_out_angle !== want.angle) begin
            $error("out_angle: expected %0d, got %0d", want.angle, o_out_angle);
            fail_cnt++;
        end
        if (o_power !== want.power) begin
            $error("power: expected %0d, got %0d", want.power, o_power);
            fail_cnt++;
        end
        if (o_last !== want.is_last) begin
            $error("last: expected %0b, got %0b", want.is_last, o_last);
            fail_cnt++;
        end
    endfunction

    // ---------------- request generation ----------------

    function automatic logic signed [15:0] pick_q15();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void push_load(int ch, int ang, logic signed [15:0] wre, wim);
        t_req r;
        r.req_type  = REQ_LOAD;
        r.channel   = IDX_W'(ch);
        r.angle     = IDX_W'(ang);
        r.sample_re = 16'($urandom);
        r.sample_im = 16'($urandom);
        r.phase_cos = 16'($urandom);
        r.phase_sin = 16'($urandom);
        r.steer_re  = wre;
        r.steer_im  = wim;
        req_backlog.push_back(r);
        if (ch < N_CH && ang < N_ANG) begin
            gen_loaded[ch*N_ANG + ang] = 1'b1;
            useful_items++;
        end
    endfunction

    // a sample only goes out once every entry of its channel has been written
    function automatic void push_sample(int ch, logic signed [15:0] sre, sim, pc, ps);
        t_req r;
        if (ch < N_CH)
            for (int a = 0; a < N_ANG; a++)
                if (!gen_loaded[ch*N_ANG + a]) push_load(ch, a, pick_q15(), pick_q15());
        r.req_type  = REQ_SAMPLE;
        r.channel   = IDX_W'(ch);
        r.angle     = IDX_W'($urandom);
        r.sample_re = sre;
        r.sample_im = sim;
        r.phase_cos = pc;
        r.phase_sin = ps;
        r.steer_re  = 16'($urandom);
        r.steer_im  = 16'($urandom);
        req_backlog.push_back(r);
        if (ch < N_CH) useful_items++;
    endfunction

    function automatic void random_sample(int ch);
        push_sample(ch, pick_q15(), pick_q15(), pick_q15(), pick_q15());
    endfunction

    function automatic void gen_traffic(int quota);
        int stop_at, pick, k;
        stop_at = useful_items + quota;
        while (useful_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                repeat ($urandom_range(3))
                    push_load($urandom_range(N_CH-1), $urandom_range(N_ANG-1),
                              pick_q15(), pick_q15());
                for (int c = 0; c < N_CH; c++) begin
                    k = $urandom_range(19);
                    if (k == 0 && c != N_CH - 1) continue;
                    random_sample(c);
                    if (k == 1 && c != N_CH - 1) random_sample(c);
                end
            end else if (pick < 85) begin
                push_load($urandom_range(63), $urandom_range(63), pick_q15(), pick_q15());
            end else if (pick < 95) begin
                random_sample($urandom_range(63, N_CH));
            end else begin
                // bin cut short, carries into the next one
                for (int c = 0; c <= $urandom_range(N_CH-2); c++) random_sample(c);
            end
        end
    endfunction

    task automatic drain();
        while (req_backlog.size() != 0 || in_valid) @(posedge i_clk);
        while (pending_powers.size() != 0) @(posedge i_clk);
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) beam_step(drv);
            if (!in_valid || o_in_ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    drv      <= req_backlog.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) check_power();
            if (hold_arm && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    initial begin
        for (int i = 0; i < N_CH*N_ANG; i++) begin
            steer_tbl[i]  = '0;
            gen_loaded[i] = 1'b0;
        end
        for (int a = 0; a < N_ANG; a++) begin
            beam_re[a] = 0;
            beam_im[a] = 0;
        end

        // extremes of the steering entries
        push_load(0, 0, 16'sh8000, 16'sh7FFF);
        push_load(0, N_ANG-1, 16'sh7FFF, 16'sh8000);
        push_load(N_CH-1, N_ANG-1, 16'sh8000, 16'sh8000);
        push_load(N_CH-1, 0, 16'sh7FFF, 16'sh7FFF);
        // out-of-range loads and samples are dropped
        push_load(63, 63, 16'sh7FFF, 16'sh7FFF);
        push_load(N_CH, 0, 16'sh1234, 16'sh4321);
        push_load(0, N_ANG, 16'sh1234, 16'sh4321);
        push_sample(63, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        push_sample(N_CH, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        // missing channels, largest phased product
        push_sample(0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
        push_sample(1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        push_sample(N_CH-1, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000);
        // repeated channel
        push_sample(3, 16'sh4000, 16'shC000, 16'sh7FFF, 16'sh0000);
        push_sample(3, 16'sh4000, 16'shC000, 16'sh7FFF, 16'sh0000);
        push_sample(N_CH-1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        // bin made of the last channel alone
        push_sample(N_CH-1, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gen_traffic(90);
        drain();

        tx_idle_pct <= 60;
        rx_idle_pct <= 19;
        gen_traffic(90);
        drain();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        hold_arm    <= 1'b1;
        gen_traffic(90);
        push_sample(N_CH-1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);

        // largest contributions on channel 0: angle 0 both parts negative,
        // angle 1 both positive, angle 2 mixed
        push_load(0, 0, 16'sh8000, 16'sh7FFF);
        push_load(0, 1, 16'sh7FFF, 16'sh8000);
        push_load(0, 2, 16'sh7FFF, 16'sh7FFF);
        for (int i = 0; i < BIG_SAMPLES; i++)
            push_sample(0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
        push_sample(N_CH-1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        drain();

        repeat (200) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
